>>> hdl/socks5_address_header_parser_unit_macros.svh
// Assertion macros for the SOCKS5 address header parser core, sahp_core.
// Every macro expects clk_i and rst_ni to be visible where it is used.
`ifndef SOCKS5_ADDRESS_HEADER_PARSER_UNIT_MACROS_SVH
`define SOCKS5_ADDRESS_HEADER_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define SAHP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define SAHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sahp_pkg.sv
// Package for the SOCKS5 address header parser: codes, beat types and constants.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sahp_pkg;

  // Address type codes carried by the first header byte.
  localparam logic [7:0] ADDR_TYPE_V4   = 8'd1;
  localparam logic [7:0] ADDR_TYPE_NAME = 8'd3;
  localparam logic [7:0] ADDR_TYPE_V6   = 8'd4;

  // Header lengths in bytes.
  localparam logic [8:0] NAME_HDR_MIN_BYTES = 9'd5;
  localparam logic [8:0] V4_HDR_BYTES       = 9'd7;
  localparam logic [8:0] V6_HDR_BYTES       = 9'd19;
  localparam logic [8:0] HOST_LEN_OVERHEAD  = 9'd4;

  // Address field lengths for the fixed-size kinds.
  localparam logic [8:0] IPV4_ADDR_LEN = 9'd4;
  localparam logic [8:0] IPV6_ADDR_LEN = 9'd16;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HLEN = 3'd1,
    PH_ADDR = 3'd2,
    PH_PHI  = 3'd3,
    PH_PLO  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_IPV4 = 2'd0,
    KIND_HOST = 2'd1,
    KIND_IPV6 = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IGNORED  = 2'd0,
    ST_BUSY     = 2'd1,
    ST_DONE     = 2'd2,
    ST_BAD_TYPE = 2'd3
  } status_e;

  // One input beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    status_e     status;
    logic        addr_valid;
    logic [7:0]  addr_byte;
    logic [7:0]  addr_index;
    logic [1:0]  addr_kind;
    logic [8:0]  bytes_remaining;
    logic [15:0] target_port;
    logic [8:0]  hdr_total_len;
  } result_t;

endpackage

>>> hdl/sahp_in_reg.sv
// Input register of the SOCKS5 address header parser.
// Holds one accepted beat until the parser core takes it; uses sahp_pkg.
`timescale 1ns / 1ps

module sahp_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sahp_pkg::in_beat_t beat_i,
  input  logic               take_i,
  output logic               valid_o,
  output sahp_pkg::in_beat_t beat_o
);
  import sahp_pkg::*;

  logic     valid_q;
  in_beat_t beat_q;

  // Stall while a held beat cannot move on this cycle.
  assign in_stall_o = valid_q && !take_i;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload, loaded only with a new beat.
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

>>> hdl/sahp_core.sv
// Parser core: the header state and the per-byte step that produces one result.
// Uses sahp_pkg and the assertion macros header.
`timescale 1ns / 1ps

module sahp_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  sahp_pkg::in_beat_t beat_i,
  output sahp_pkg::result_t  res_o
);
  import sahp_pkg::*;

  `include "socks5_address_header_parser_unit_macros.svh"

  phase_e     phase_q, phase_d;
  kind_e      kind_q, kind_d;
  logic [7:0] host_len_q, host_len_d;
  logic [8:0] byte_count_q, byte_count_d;
  logic [7:0] port_high_q, port_high_d;

  logic [8:0] first_idx;
  logic [8:0] addr_idx;
  logic [8:0] addr_len;
  logic [8:0] count_inc;
  logic [8:0] total_after;
  logic [8:0] total_before;

  // Address index and length of the header in progress.
  assign first_idx = (kind_q == KIND_HOST) ? 9'd2 : 9'd1;
  assign addr_idx  = (byte_count_q >= first_idx) ? (byte_count_q - first_idx) : 9'd0;
  assign count_inc = byte_count_q + 9'd1;

  always_comb begin
    case (kind_q)
      KIND_IPV4: addr_len = IPV4_ADDR_LEN;
      KIND_IPV6: addr_len = IPV6_ADDR_LEN;
      default:   addr_len = {1'b0, host_len_q};
    endcase
  end

  // Next state.
  always_comb begin
    phase_d      = phase_q;
    kind_d       = kind_q;
    host_len_d   = host_len_q;
    byte_count_d = byte_count_q;
    port_high_d  = port_high_q;
    if (beat_i.start_req) begin
      host_len_d   = 8'd0;
      port_high_d  = 8'd0;
      byte_count_d = 9'd1;
      unique case (beat_i.data_byte)
        ADDR_TYPE_V4: begin
          kind_d  = KIND_IPV4;
          phase_d = PH_ADDR;
        end
        ADDR_TYPE_V6: begin
          kind_d  = KIND_IPV6;
          phase_d = PH_ADDR;
        end
        ADDR_TYPE_NAME: begin
          kind_d  = KIND_HOST;
          phase_d = PH_HLEN;
        end
        default: begin
          kind_d       = KIND_IPV4;
          byte_count_d = 9'd0;
          phase_d      = PH_IDLE;
        end
      endcase
    end else begin
      unique case (phase_q)
        PH_HLEN: begin
          host_len_d   = beat_i.data_byte;
          byte_count_d = 9'd2;
          phase_d      = (beat_i.data_byte == 8'd0) ? PH_PHI : PH_ADDR;
        end
        PH_ADDR: begin
          byte_count_d = count_inc;
          if (({1'b0, addr_idx} + 10'd1) >= {1'b0, addr_len}) begin
            phase_d = PH_PHI;
          end
        end
        PH_PHI: begin
          port_high_d  = beat_i.data_byte;
          byte_count_d = count_inc;
          phase_d      = PH_PLO;
        end
        PH_PLO: begin
          byte_count_d = count_inc;
          phase_d      = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // Header length as known after this byte, and as known before it.
  always_comb begin
    case (kind_d)
      KIND_IPV4: total_after = V4_HDR_BYTES;
      KIND_IPV6: total_after = V6_HDR_BYTES;
      default: begin
        total_after = (phase_d == PH_HLEN) ? NAME_HDR_MIN_BYTES
                                           : (HOST_LEN_OVERHEAD + {1'b0, host_len_d});
      end
    endcase
    case (kind_q)
      KIND_IPV4: total_before = V4_HDR_BYTES;
      KIND_IPV6: total_before = V6_HDR_BYTES;
      default:   total_before = HOST_LEN_OVERHEAD + {1'b0, host_len_q};
    endcase
  end

  // Result fields.
  always_comb begin
    res_o                 = '0;
    res_o.status          = ST_IGNORED;
    if (beat_i.start_req) begin
      if (phase_d == PH_IDLE) begin
        res_o.status = ST_BAD_TYPE;
      end else begin
        res_o.status          = ST_BUSY;
        res_o.addr_kind       = kind_d;
        res_o.bytes_remaining = (total_after > byte_count_d) ? (total_after - byte_count_d)
                                                             : 9'd0;
      end
    end else begin
      unique case (phase_q) inside
        PH_HLEN, PH_ADDR, PH_PHI: begin
          res_o.status          = ST_BUSY;
          res_o.addr_kind       = kind_d;
          res_o.bytes_remaining = (total_after > byte_count_d) ? (total_after - byte_count_d)
                                                               : 9'd0;
          if (phase_q == PH_ADDR) begin
            res_o.addr_valid = 1'b1;
            res_o.addr_byte  = beat_i.data_byte;
            res_o.addr_index = addr_idx[7:0];
          end
        end
        PH_PLO: begin
          res_o.status        = ST_DONE;
          res_o.addr_kind     = kind_q;
          res_o.target_port   = {port_high_q, beat_i.data_byte};
          res_o.hdr_total_len = total_before;
        end
        default: begin
          res_o.status = ST_IGNORED;
        end
      endcase
    end
  end

  // State registers advance only when a beat moves to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      kind_q       <= KIND_IPV4;
      host_len_q   <= 8'd0;
      byte_count_q <= 9'd0;
      port_high_q  <= 8'd0;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      kind_q       <= kind_d;
      host_len_q   <= host_len_d;
      byte_count_q <= byte_count_d;
      port_high_q  <= port_high_d;
    end
  end

  `SAHP_ASSERT_NEXT(a_port_low_ends,
                    fire_i && !beat_i.start_req && phase_q == PH_PLO,
                    phase_q == PH_IDLE,
                    "parser did not go idle after the last port byte")
  `SAHP_ASSERT_IMPL(a_addr_only_busy,
                    fire_i && res_o.addr_valid,
                    res_o.status == ST_BUSY && res_o.addr_kind == kind_q,
                    "address byte reported outside an address field")
  `SAHP_ASSERT_IMPL(a_done_fields,
                    fire_i && res_o.status == ST_DONE,
                    res_o.bytes_remaining == 9'd0 && res_o.hdr_total_len >= HOST_LEN_OVERHEAD,
                    "completed header with bad length fields")
  `SAHP_ASSERT_NEXT(a_bad_type_idle,
                    fire_i && res_o.status == ST_BAD_TYPE,
                    phase_q == PH_IDLE && byte_count_q == 9'd0,
                    "unknown type byte left the parser busy")

endmodule

>>> hdl/sahp_out_reg.sv
// Result register of the SOCKS5 address header parser.
// Holds one result beat while the receiver stalls; uses sahp_pkg.
`timescale 1ns / 1ps

module sahp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  sahp_pkg::result_t res_i,
  output logic              take_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sahp_pkg::result_t res_o
);
  import sahp_pkg::*;

  logic    valid_q;
  result_t res_q;

  // The register can load when empty or when its beat leaves this cycle.
  assign take_o = valid_i && (!valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || !out_stall_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> hdl/socks5_address_header_parser_unit.sv
// SOCKS5 address header parser: one header byte in, one result beat out.
// Usage: beats enter on in_valid_i/in_stall_o with data_byte_i and start_req_i;
// start_req_i marks the address type byte and restarts parsing at any point.
// Each input beat yields exactly one result beat on out_valid_o/out_stall_i:
// status, the address byte with its index, the address kind, the bytes still
// needed and, on the last port byte, the port and the total header length.
// The held byte is parsed combinationally and its result is written to the result
// register when that register is empty or its beat leaves. Throughput is one byte
// per cycle while out_stall_i is low; the header state updates in the same cycle
// that a byte moves into the result register, so back-to-back bytes chain.
// Reset (rst_ni low, asynchronous) empties both registers and puts the parser
// idle; bytes without start_req_i while idle give an ignored-status result.
// When the receiver stalls, the result beat holds; an empty input register
// still takes one more byte, then in_stall_o stays high until the result is taken.
// Depends on sahp_pkg, sahp_in_reg, sahp_core and sahp_out_reg.
`timescale 1ns / 1ps

module socks5_address_header_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        addr_valid_o,
  output logic [7:0]  addr_byte_o,
  output logic [7:0]  addr_index_o,
  output logic [1:0]  addr_kind_o,
  output logic [8:0]  bytes_remaining_o,
  output logic [15:0] target_port_o,
  output logic [8:0]  hdr_total_len_o
);
  import sahp_pkg::*;

  in_beat_t in_beat;
  in_beat_t held_beat;
  logic     held_valid;
  logic     take;
  result_t  step_res;
  result_t  out_res;

  assign in_beat.data_byte = data_byte_i;
  assign in_beat.start_req = start_req_i;

  // Input register.
  sahp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .beat_i     (in_beat),
    .take_i     (take),
    .valid_o    (held_valid),
    .beat_o     (held_beat)
  );

  // Header state and per-byte step.
  sahp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (take),
    .beat_i (held_beat),
    .res_o  (step_res)
  );

  // Result register.
  sahp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (held_valid),
    .res_i       (step_res),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  // Result fields to ports.
  assign status_o          = out_res.status;
  assign addr_valid_o      = out_res.addr_valid;
  assign addr_byte_o       = out_res.addr_byte;
  assign addr_index_o      = out_res.addr_index;
  assign addr_kind_o       = out_res.addr_kind;
  assign bytes_remaining_o = out_res.bytes_remaining;
  assign target_port_o     = out_res.target_port;
  assign hdr_total_len_o   = out_res.hdr_total_len;

endmodule

>>> tb/tb_socks5_address_header_parser_unit.sv
// Self-checking testbench for socks5_address_header_parser_unit: random header streams
// are checked beat by beat against a behavioral parser model kept in this file.
// Depends on sahp_pkg and the socks5_address_header_parser_unit RTL.
`timescale 1ns / 1ps

module tb_socks5_address_header_parser_unit;
  import sahp_pkg::*;

  localparam int HEADER_BYTES   = 1850;
  localparam int WATCHDOG_LIMIT = 600;
  localparam int DRAIN_CYCLES   = 12;
  localparam int HOLD_CYCLES    = 80;

  // One queued input byte and the idle cycles the sender leaves after it.
  typedef struct packed {
    in_beat_t   beat;
    logic [2:0] gap;
  } header_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'd0;
  logic        start_req_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic        addr_valid_o;
  logic [7:0]  addr_byte_o;
  logic [7:0]  addr_index_o;
  logic [1:0]  addr_kind_o;
  logic [8:0]  bytes_remaining_o;
  logic [15:0] target_port_o;
  logic [8:0]  hdr_total_len_o;

  header_byte_t pending_bytes[$];
  result_t      expected_parse[$];

  int live_items   = 0;
  int queued_bytes = 0;
  int gap_left     = 0;
  int results_seen = 0;
  int stall_left   = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;
  int err_count    = 0;

  // Parser state as the block should hold it.
  phase_e     hp_phase    = PH_IDLE;
  kind_e      hp_kind     = KIND_IPV4;
  logic [7:0] hp_host_len = 8'd0;
  logic [8:0] hp_count    = 9'd0;
  logic [7:0] hp_port_hi  = 8'd0;

  socks5_address_header_parser_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .start_req_i       (start_req_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .addr_valid_o      (addr_valid_o),
    .addr_byte_o       (addr_byte_o),
    .addr_index_o      (addr_index_o),
    .addr_kind_o       (addr_kind_o),
    .bytes_remaining_o (bytes_remaining_o),
    .target_port_o     (target_port_o),
    .hdr_total_len_o   (hdr_total_len_o)
  );

  always #5 clk_i = ~clk_i;

  // Header length as far as it is known; a host header counts as the minimum
  // until its length byte has arrived.
  function automatic logic [8:0] header_total();
    if (hp_kind == KIND_IPV4) return V4_HDR_BYTES;
    if (hp_kind == KIND_IPV6) return V6_HDR_BYTES;
    if (hp_phase == PH_HLEN) return NAME_HDR_MIN_BYTES;
    return HOST_LEN_OVERHEAD + {1'b0, hp_host_len};
  endfunction

  function automatic logic [8:0] bytes_left();
    logic [8:0] total;
    total = header_total();
    return (total > hp_count) ? total - hp_count : 9'd0;
  endfunction

  // Advances the parser state by one byte and returns the result beat it gives.
  function automatic result_t parse_byte(input logic [7:0] b, input logic start);
    result_t    r;
    logic [8:0] first;
    logic [8:0] idx;
    logic [8:0] alen;
    r = '0;
    if (start) begin
      hp_host_len = 8'd0;
      hp_port_hi  = 8'd0;
      hp_count    = 9'd1;
      r.status    = ST_BUSY;
      case (b)
        ADDR_TYPE_V4: begin
          hp_kind  = KIND_IPV4;
          hp_phase = PH_ADDR;
        end
        ADDR_TYPE_V6: begin
          hp_kind  = KIND_IPV6;
          hp_phase = PH_ADDR;
        end
        ADDR_TYPE_NAME: begin
          hp_kind  = KIND_HOST;
          hp_phase = PH_HLEN;
        end
        default: begin
          hp_kind  = KIND_IPV4;
          hp_count = 9'd0;
          hp_phase = PH_IDLE;
          r.status = ST_BAD_TYPE;
        end
      endcase
      if (r.status == ST_BUSY) begin
        r.addr_kind       = hp_kind;
        r.bytes_remaining = bytes_left();
      end
    end else begin
      case (hp_phase)
        PH_HLEN: begin
          hp_host_len       = b;
          hp_count          = 9'd2;
          hp_phase          = (b == 8'd0) ? PH_PHI : PH_ADDR;
          r.status          = ST_BUSY;
          r.addr_kind       = hp_kind;
          r.bytes_remaining = bytes_left();
        end
        PH_ADDR: begin
          first = (hp_kind == KIND_HOST) ? 9'd2 : 9'd1;
          idx   = (hp_count >= first) ? hp_count - first : 9'd0;
          alen  = (hp_kind == KIND_IPV4) ? IPV4_ADDR_LEN :
                  (hp_kind == KIND_IPV6) ? IPV6_ADDR_LEN : {1'b0, hp_host_len};
          r.addr_valid = 1'b1;
          r.addr_byte  = b;
          r.addr_index = idx[7:0];
          hp_count     = hp_count + 9'd1;
          if (idx + 9'd1 >= alen) hp_phase = PH_PHI;
          r.status          = ST_BUSY;
          r.addr_kind       = hp_kind;
          r.bytes_remaining = bytes_left();
        end
        PH_PHI: begin
          hp_port_hi        = b;
          hp_count          = hp_count + 9'd1;
          hp_phase          = PH_PLO;
          r.status          = ST_BUSY;
          r.addr_kind       = hp_kind;
          r.bytes_remaining = bytes_left();
        end
        PH_PLO: begin
          hp_count        = hp_count + 9'd1;
          r.status        = ST_DONE;
          r.addr_kind     = hp_kind;
          r.target_port   = {hp_port_hi, b};
          r.hdr_total_len = header_total();
          hp_phase        = PH_IDLE;
        end
        default: hp_phase = PH_IDLE;
      endcase
    end
    return r;
  endfunction

  task automatic cmp_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  // Queues one byte; in some stretches the sender never idles.
  task automatic queue_byte(input logic [7:0] b, input logic start, input bit counted);
    header_byte_t item;
    item.beat.data_byte = b;
    item.beat.start_req = start;
    item.gap = (((queued_bytes / 200) % 3) == 1) ? 3'd0 : 3'($urandom_range(0, 4));
    pending_bytes.push_back(item);
    queued_bytes++;
    if (counted) live_items++;
  endtask

  // Queues a header of the given type with random content, cut after keep bytes.
  task automatic queue_header(input logic [7:0] atyp, input int keep);
    logic [7:0] hdr [0:260];
    logic [7:0] hlen;
    int         n;
    int         alen;
    hdr[0] = atyp;
    n = 1;
    if (atyp == ADDR_TYPE_NAME) begin
      hlen = ($urandom_range(0, 49) == 0) ? 8'd255 : 8'($urandom_range(0, 12));
      hdr[1] = hlen;
      n = 2;
      alen = hlen;
    end else begin
      alen = (atyp == ADDR_TYPE_V4) ? 4 : 16;
    end
    for (int i = 0; i < alen + 2; i++) begin
      hdr[n] = 8'($urandom_range(0, 255));
      n++;
    end
    if (keep > n) keep = n;
    for (int i = 0; i < keep; i++) queue_byte(hdr[i], i == 0, 1'b1);
  endtask

  function automatic logic [7:0] pick_atyp();
    case ($urandom_range(0, 2))
      0: return ADDR_TYPE_V4;
      1: return ADDR_TYPE_NAME;
      default: return ADDR_TYPE_V6;
    endcase
  endfunction

  // Sender: counts accepted beats into the model, then offers the next queued byte.
  always @(posedge clk_i) begin : send_proc
    header_byte_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_parse.push_back(parse_byte(data_byte_i, start_req_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (pending_bytes.size() != 0) begin
          nxt = pending_bytes.pop_front();
          data_byte_i <= nxt.beat.data_byte;
          start_req_i <= nxt.beat.start_req;
          in_valid_i  <= 1'b1;
          gap_left    <= nxt.gap;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat, then stalls at random. Twice it holds off
  // for a long stretch so the block backs up and stalls its input.
  always @(posedge clk_i) begin : recv_proc
    result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_parse.size() == 0) begin
          $error("result beat with no byte waiting for it");
          err_count++;
        end else begin
          want = expected_parse.pop_front();
          cmp_field("status", want.status, status_o);
          cmp_field("addr_valid", want.addr_valid, addr_valid_o);
          cmp_field("addr_byte", want.addr_byte, addr_byte_o);
          cmp_field("addr_index", want.addr_index, addr_index_o);
          cmp_field("addr_kind", want.addr_kind, addr_kind_o);
          cmp_field("bytes_remaining", want.bytes_remaining, bytes_remaining_o);
          cmp_field("target_port", want.target_port, target_port_o);
          cmp_field("hdr_total_len", want.hdr_total_len, hdr_total_len_o);
        end
        results_seen++;
        stall_left = (((results_seen / 170) % 3) == 2) ? 0 : $urandom_range(0, 4);
        if (results_seen == 400 || results_seen == 1300) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int choice;
    int cnt;
    logic st;

    // Directed bytes: an idle byte, unknown types, an IPv6 header cut short by a new
    // start, an IPv4 header with extreme bytes, a zero-length host, a short host name.
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b1, 1'b1);
    queue_byte(8'hFF, 1'b1, 1'b1);
    queue_byte(ADDR_TYPE_V6, 1'b1, 1'b1);
    queue_byte(8'h80, 1'b0, 1'b1);
    queue_byte(ADDR_TYPE_V4, 1'b1, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b1);
    queue_byte(8'hFF, 1'b0, 1'b1);
    queue_byte(8'hA5, 1'b0, 1'b1);
    queue_byte(8'h5A, 1'b0, 1'b1);
    queue_byte(8'hFF, 1'b0, 1'b1);
    queue_byte(8'hFF, 1'b0, 1'b1);
    queue_byte(ADDR_TYPE_NAME, 1'b1, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b1);
    queue_byte(8'h01, 1'b0, 1'b1);
    queue_byte(ADDR_TYPE_NAME, 1'b1, 1'b1);
    queue_byte(8'h01, 1'b0, 1'b1);
    queue_byte(8'h61, 1'b0, 1'b1);
    queue_byte(8'h12, 1'b0, 1'b1);
    queue_byte(8'h34, 1'b0, 1'b1);
    queue_byte(8'h55, 1'b0, 1'b0);

    // Random part: mostly complete headers, some cut short, some noise bytes.
    while (live_items < HEADER_BYTES) begin
      choice = $urandom_range(0, 99);
      if (choice < 75) begin
        queue_header(pick_atyp(), 300);
      end else if (choice < 88) begin
        queue_header(pick_atyp(), $urandom_range(1, 18));
      end else begin
        cnt = $urandom_range(1, 3);
        for (int i = 0; i < cnt; i++) begin
          st = 1'($urandom_range(0, 1));
          queue_byte((st && $urandom_range(0, 1)) ? pick_atyp() : 8'($urandom_range(0, 255)),
                     st, st);
        end
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_parse.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_parse.size() != 0) begin
      $error("%0d result beats never arrived", expected_parse.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/sahp_pkg.sv
hdl/sahp_in_reg.sv
hdl/sahp_core.sv
hdl/sahp_out_reg.sv
hdl/socks5_address_header_parser_unit.sv
tb/tb_socks5_address_header_parser_unit.sv
